// ===== sv/nec_ir_frame_transmitter_unit_assert.svh =====
// Assertion macros for the NEC IR frame transmitter.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef NEC_IR_FRAME_TRANSMITTER_UNIT_ASSERT_SVH
`define NEC_IR_FRAME_TRANSMITTER_UNIT_ASSERT_SVH

// Check an implication that holds within the same cycle.
`define NECIRTX_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check an implication in the following cycle.
`define NECIRTX_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/necirtx_pkg.sv =====
`timescale 1ns / 1ps

package necirtx_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_BYTES_DEF  = 4;
    localparam int TIMER_BITS_DEF = 16;

    // Field widths.
    localparam int PHASE_W     = 3;
    localparam int COUNT_W     = 3;
    localparam int DUR_W       = 16;
    localparam int PAYLOAD_W   = 32;
    localparam int PAYLOAD_NB  = PAYLOAD_W / 8;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;

    // Register reset values.
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_RST   = 32'h55AA_FF00;
    localparam logic [COUNT_W-1:0]   COUNT_RST     = 3'd4;
    localparam logic [DUR_W-1:0]     LEAD_MARK_RST = 16'd900;
    localparam logic [DUR_W-1:0]     LEAD_SPC_RST  = 16'd450;
    localparam logic [DUR_W-1:0]     BIT_MARK_RST  = 16'd56;
    localparam logic [DUR_W-1:0]     ONE_SPC_RST   = 16'd169;
    localparam logic [DUR_W-1:0]     GAP_RST       = 16'd10800;

    // Transmit phase, also the encoding of the phase output.
    typedef enum logic [PHASE_W-1:0] {
        PH_GAP        = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4
    } phase_t;

    // Register map index (byte address / 4).
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PAYLOAD    = 3'd0,
        REG_BYTE_COUNT = 3'd1,
        REG_LEAD_MARK  = 3'd2,
        REG_LEAD_SPACE = 3'd3,
        REG_BIT_MARK   = 3'd4,
        REG_ONE_SPACE  = 3'd5,
        REG_GAP        = 3'd6
    } reg_idx_t;

endpackage

// ===== sv/nec_ir_frame_transmitter_unit.sv =====
`timescale 1ns / 1ps
// NEC IR frame transmitter: one enable beat in, one carrier/phase/frame_done beat out.
// The result of a beat is registered and shown in the cycle after the beat is accepted.
// One beat per cycle while the output is not stalled; the countdown, phase step and bit
// pick are all combinational between the state registers and the output register.
// Reset (rst_n low, asynchronous): gap phase with one tick left, bit index and byte
// cleared, no result pending, all configuration registers at their defaults.

module nec_ir_frame_transmitter_unit #(
    parameter int MAX_BYTES  = necirtx_pkg::MAX_BYTES_DEF,
    parameter int TIMER_BITS = necirtx_pkg::TIMER_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 enable,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 carrier_on,
    output logic [necirtx_pkg::PHASE_W-1:0]      phase,
    output logic                                 frame_done,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [necirtx_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [necirtx_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [necirtx_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                 pready
);

    import necirtx_pkg::*;

    // Bit index runs from 0 up to MAX_BYTES*8 inclusive.
    localparam int BI_W = $clog2(MAX_BYTES * 8 + 1);
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [COUNT_W-1:0]   byte_count_reg;
    logic [DUR_W-1:0]     lead_mark_reg;
    logic [DUR_W-1:0]     lead_space_reg;
    logic [DUR_W-1:0]     bit_mark_reg;
    logic [DUR_W-1:0]     one_space_reg;
    logic [DUR_W-1:0]     gap_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_reg    <= PAYLOAD_RST;
            byte_count_reg <= COUNT_RST;
            lead_mark_reg  <= LEAD_MARK_RST;
            lead_space_reg <= LEAD_SPC_RST;
            bit_mark_reg   <= BIT_MARK_RST;
            one_space_reg  <= ONE_SPC_RST;
            gap_reg        <= GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PAYLOAD:    payload_reg    <= pwdata;
                REG_BYTE_COUNT: byte_count_reg <= pwdata[COUNT_W-1:0];
                REG_LEAD_MARK:  lead_mark_reg  <= pwdata[DUR_W-1:0];
                REG_LEAD_SPACE: lead_space_reg <= pwdata[DUR_W-1:0];
                REG_BIT_MARK:   bit_mark_reg   <= pwdata[DUR_W-1:0];
                REG_ONE_SPACE:  one_space_reg  <= pwdata[DUR_W-1:0];
                REG_GAP:        gap_reg        <= pwdata[DUR_W-1:0];
                default:        ;   // unmapped address: drop the write
            endcase
        end
    end

    // Read back, zero-extended; unmapped addresses read zero.
    always_comb
    begin
        unique case (cfg_idx)
            REG_PAYLOAD:    prdata = payload_reg;
            REG_BYTE_COUNT: prdata = APB_DATA_W'(byte_count_reg);
            REG_LEAD_MARK:  prdata = APB_DATA_W'(lead_mark_reg);
            REG_LEAD_SPACE: prdata = APB_DATA_W'(lead_space_reg);
            REG_BIT_MARK:   prdata = APB_DATA_W'(bit_mark_reg);
            REG_ONE_SPACE:  prdata = APB_DATA_W'(one_space_reg);
            REG_GAP:        prdata = APB_DATA_W'(gap_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: one output register parts the two channels. A new beat
    // is taken whenever that register is empty or being drained.
    // ------------------------------------------------------------------
    logic in_accept;

    assign in_stall  = out_valid && out_stall;
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Transmit state
    // ------------------------------------------------------------------
    phase_t                phase_reg,      phase_next;
    logic [TIMER_BITS-1:0] tick_timer_reg, tick_timer_next;
    logic [BI_W-1:0]       bit_index_reg,  bit_index_next;
    logic [7:0]            cur_byte_reg,   cur_byte_next;

    // Durations are masked to the timer width; a zero length counts as one tick.
    function automatic logic [TIMER_BITS-1:0] load_ticks(input logic [DUR_W-1:0] v);
        logic [TIMER_BITS-1:0] t;
        t = TIMER_BITS'(v);
        return (t == '0) ? TIMER_ONE : t;
    endfunction

    // Clamp the byte count to 1..MAX_BYTES and turn it into a bit limit.
    logic [3:0]      eff_count;
    logic [BI_W-1:0] bit_limit;

    always_comb
    begin
        if (byte_count_reg == '0)
            eff_count = 4'd1;
        else if ({1'b0, byte_count_reg} > 4'(MAX_BYTES))
            eff_count = 4'(MAX_BYTES);
        else
            eff_count = {1'b0, byte_count_reg};
        bit_limit = BI_W'({eff_count, 3'b000});
    end

    // Byte and bit selected by the bit index; bytes past the register read zero.
    logic [7:0] byte_sel;
    logic [7:0] payload_byte;
    logic [7:0] byte_now;
    logic       bit_val;

    always_comb
    begin
        byte_sel = 8'(bit_index_reg >> 3);
        if (byte_sel < 8'(PAYLOAD_NB))
            payload_byte = payload_reg[byte_sel[1:0]*8 +: 8];
        else
            payload_byte = '0;
        byte_now = (bit_index_reg[2:0] == 3'd0) ? payload_byte : cur_byte_reg;
        bit_val  = byte_now[bit_index_reg[2:0]];
    end

    // Next state and result of one tick.
    logic   expired;
    logic   carrier_next;
    logic   done_next;
    phase_t phase_out_next;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_timer_next = tick_timer_reg;
        bit_index_next  = bit_index_reg;
        cur_byte_next   = cur_byte_reg;
        carrier_next    = 1'b0;
        done_next       = 1'b0;
        phase_out_next  = phase_reg;
        expired         = (tick_timer_reg <= TIMER_ONE);

        if (!enable)
        begin
            // Drop back to the gap with one tick left, carrier off.
            phase_next      = PH_GAP;
            tick_timer_next = TIMER_ONE;
            bit_index_next  = '0;
            phase_out_next  = PH_GAP;
        end
        else
        begin
            if (!expired)
                tick_timer_next = tick_timer_reg - TIMER_ONE;

            unique case (phase_reg)
                PH_LEAD_MARK:
                begin
                    carrier_next = 1'b1;
                    if (expired)
                    begin
                        phase_next      = PH_LEAD_SPACE;
                        tick_timer_next = load_ticks(lead_space_reg);
                    end
                end
                PH_LEAD_SPACE:
                begin
                    if (expired)
                    begin
                        phase_next      = PH_BIT_MARK;
                        tick_timer_next = load_ticks(bit_mark_reg);
                    end
                end
                PH_BIT_MARK:
                begin
                    carrier_next = 1'b1;
                    if (expired)
                    begin
                        if (bit_index_reg >= bit_limit)
                        begin
                            // Stop mark ends: frame complete.
                            bit_index_next  = '0;
                            phase_next      = PH_GAP;
                            tick_timer_next = load_ticks(gap_reg);
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            cur_byte_next   = byte_now;
                            bit_index_next  = bit_index_reg + BI_W'(1);
                            phase_next      = PH_BIT_SPACE;
                            tick_timer_next = bit_val ? load_ticks(one_space_reg)
                                                      : load_ticks(bit_mark_reg);
                        end
                    end
                end
                PH_BIT_SPACE:
                begin
                    if (expired)
                    begin
                        phase_next      = PH_BIT_MARK;
                        tick_timer_next = load_ticks(bit_mark_reg);
                    end
                end
                default:
                begin
                    // Gap, or any stray code handled as the gap.
                    phase_out_next = PH_GAP;
                    if (expired)
                    begin
                        phase_next      = PH_LEAD_MARK;
                        tick_timer_next = load_ticks(lead_mark_reg);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_GAP;
            tick_timer_reg <= TIMER_ONE;
            bit_index_reg  <= '0;
            cur_byte_reg   <= '0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            tick_timer_reg <= tick_timer_next;
            bit_index_reg  <= bit_index_next;
            cur_byte_reg   <= cur_byte_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold while stalled, load on every accepted beat.
    // ------------------------------------------------------------------
    logic   out_valid_reg, out_valid_next;
    logic   carrier_reg;
    logic   done_reg;
    phase_t phase_out_reg;

    assign out_valid_next = in_accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            carrier_reg   <= carrier_next;
            done_reg      <= done_next;
            phase_out_reg <= phase_out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign carrier_on = carrier_reg;
    assign frame_done = done_reg;
    assign phase      = phase_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "nec_ir_frame_transmitter_unit_assert.svh"

    `NECIRTX_ASSERT_SAME(a_done_in_mark, out_valid && frame_done, carrier_on && phase_out_reg == PH_BIT_MARK, "frame_done outside a stop mark")
    `NECIRTX_ASSERT_SAME(a_carrier_phase, out_valid && carrier_on, phase_out_reg == PH_LEAD_MARK || phase_out_reg == PH_BIT_MARK, "carrier on in a space phase")
    `NECIRTX_ASSERT_NEXT(a_disable_idle, in_accept && !enable, phase_reg == PH_GAP && tick_timer_reg == TIMER_ONE && bit_index_reg == '0, "disable did not force the gap")
    `NECIRTX_ASSERT_SAME(a_timer_nonzero, 1'b1, tick_timer_reg != '0, "tick timer reached zero")
    `NECIRTX_ASSERT_SAME(a_bit_index_range, 1'b1, bit_index_reg <= BI_W'(MAX_BYTES * 8), "bit index past the frame")

endmodule
